// ===== rtl/trie_insert_and_lookup_top_assert.svh =====
// ----------------------------------------------------------------------------
// trie assertion macros
// shared property forms for the trie checker
// ----------------------------------------------------------------------------
`ifndef TRIE_INSERT_AND_LOOKUP_TOP_ASSERT_SVH
`define TRIE_INSERT_AND_LOOKUP_TOP_ASSERT_SVH

// same-cycle implication
`define TIL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("til assertion failed");

// next-cycle implication
`define TIL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("til assertion failed");

`endif

// ===== rtl/til_pkg.sv =====
// ----------------------------------------------------------------------------
// til_pkg
// constants, request and response types for the prefix trie
// ----------------------------------------------------------------------------
package til_pkg;

    localparam int NODE_COUNT    = 1024;
    localparam int ALPHABET_SIZE = 26;
    localparam int LINK_DEPTH    = NODE_COUNT * ALPHABET_SIZE;
    localparam int NODE_W        = $clog2(NODE_COUNT);
    localparam int USED_W        = NODE_W + 1;
    localparam int SLOT_W        = $clog2(LINK_DEPTH);
    localparam int CMD_W         = 2;
    localparam int LETTER_W      = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [LETTER_W-1:0] letter;
        logic                last;
    } t_req;

    typedef struct packed {
        logic found;
        logic full_res;
    } t_rsp;

endpackage

// ===== rtl/til_ram.sv =====
// ----------------------------------------------------------------------------
// til_ram
// single-port ram with registered read data
// ----------------------------------------------------------------------------
module til_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/trie_insert_and_lookup_top.sv =====
// sequence: a letter runs through the slot multiply-add, the single-port
// link memory read and the write-back, then the end state; at a word end
// an insert writes its end mark or a search reads it, then the response
// register loads; a letter of a stopped word or an out-of-range letter
// goes straight to the end state; requests stall until the block is idle
// reset: synchronous, then a clearing pass over the 26624 link slots
// zeroes links and end marks while requests are stalled
// ----------------------------------------------------------------------------
// trie_insert_and_lookup_top
// letter-serial prefix trie with insert, whole-word search and prefix test
// ----------------------------------------------------------------------------
module trie_insert_and_lookup_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  til_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output til_pkg::t_rsp o_rsp
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_READ,
        S_LINK,
        S_END,
        S_MARK,
        S_OUT
    } t_state;

    localparam logic [til_pkg::SLOT_W-1:0] ALPHA_C =
        til_pkg::SLOT_W'(til_pkg::ALPHABET_SIZE);
    localparam logic [til_pkg::SLOT_W-1:0] CLR_LAST =
        til_pkg::SLOT_W'(til_pkg::LINK_DEPTH - 1);
    localparam logic [til_pkg::SLOT_W-1:0] MARK_DEPTH_C =
        til_pkg::SLOT_W'(til_pkg::NODE_COUNT);
    localparam logic [til_pkg::USED_W-1:0] USED_MAX =
        til_pkg::USED_W'(til_pkg::NODE_COUNT);
    localparam logic [til_pkg::LETTER_W-1:0] LETTER_LIM =
        til_pkg::LETTER_W'(til_pkg::ALPHABET_SIZE);

    t_state                      r_state,  n_state;
    logic [til_pkg::SLOT_W-1:0]  r_clr,    n_clr;
    logic [til_pkg::USED_W-1:0]  r_used,   n_used;
    logic [til_pkg::NODE_W-1:0]  r_cursor, n_cursor;
    logic                        r_missed, n_missed;
    logic                        r_ovf,    n_ovf;
    til_pkg::t_req               r_req,    n_req;
    logic [til_pkg::SLOT_W-1:0]  r_slot,   n_slot;
    logic                        r_found,  n_found;
    logic                        r_full,   n_full;
    til_pkg::t_rsp               r_rsp,    n_rsp;
    logic                        r_rsp_valid, n_rsp_valid;

    logic                        link_we;
    logic [til_pkg::SLOT_W-1:0]  link_addr;
    logic [til_pkg::NODE_W-1:0]  link_wdata;
    logic [til_pkg::NODE_W-1:0]  link_rdata;
    logic                        mark_we;
    logic [til_pkg::NODE_W-1:0]  mark_addr;
    logic                        mark_wdata;
    logic                        mark_rdata;
    logic                        word_ok;
    logic                        alloc;
    logic                        req_take;

    assign word_ok  = !r_missed && !r_ovf;
    assign alloc    = (link_rdata == '0) && (r_req.cmd == til_pkg::CMD_INSERT)
                      && (r_used < USED_MAX);
    assign req_take = (r_state == S_IDLE) && i_req_valid;

    // memory port control
    always_comb begin
        link_we    = 1'b0;
        link_addr  = r_slot;
        link_wdata = r_used[til_pkg::NODE_W-1:0];
        mark_we    = 1'b0;
        mark_addr  = r_cursor;
        mark_wdata = 1'b1;
        case (r_state)
            S_CLEAR: begin
                link_we    = 1'b1;
                link_addr  = r_clr;
                link_wdata = '0;
                mark_we    = (r_clr < MARK_DEPTH_C);
                mark_addr  = r_clr[til_pkg::NODE_W-1:0];
                mark_wdata = 1'b0;
            end
            S_LINK: begin
                link_we = alloc;
            end
            S_END: begin
                mark_we = r_req.last && (r_req.cmd == til_pkg::CMD_INSERT) && word_ok;
            end
            default: begin
            end
        endcase
    end

    til_ram #(
        .DEPTH (til_pkg::LINK_DEPTH),
        .WIDTH (til_pkg::NODE_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_addr  (link_addr),
        .i_wdata (link_wdata),
        .o_rdata (link_rdata)
    );

    til_ram #(
        .DEPTH (til_pkg::NODE_COUNT),
        .WIDTH (1)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_addr  (mark_addr),
        .i_wdata (mark_wdata),
        .o_rdata (mark_rdata)
    );

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_used      = r_used;
        n_cursor    = r_cursor;
        n_missed    = r_missed;
        n_ovf       = r_ovf;
        n_req       = r_req;
        n_slot      = r_slot;
        n_found     = r_found;
        n_full      = r_full;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && i_rsp_stall;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_take) begin
                    n_req = i_req;
                    if (r_missed || r_ovf) begin
                        n_state = S_END;
                    end else if (i_req.letter >= LETTER_LIM) begin
                        n_missed = 1'b1;
                        n_state  = S_END;
                    end else begin
                        n_state = S_ADDR;
                    end
                end
            end
            S_ADDR: begin
                n_slot  = til_pkg::SLOT_W'(r_cursor) * ALPHA_C
                          + til_pkg::SLOT_W'(r_req.letter);
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_LINK;
            end
            S_LINK: begin
                if (link_rdata != '0) begin
                    n_cursor = link_rdata;
                end else if (r_req.cmd != til_pkg::CMD_INSERT) begin
                    n_missed = 1'b1;
                end else if (r_used >= USED_MAX) begin
                    n_ovf = 1'b1;
                end else begin
                    n_cursor = r_used[til_pkg::NODE_W-1:0];
                    n_used   = r_used + 1'b1;
                end
                n_state = S_END;
            end
            S_END: begin
                if (!r_req.last) begin
                    n_state = S_IDLE;
                end else begin
                    case (r_req.cmd)
                        til_pkg::CMD_INSERT: begin
                            n_found = 1'b0;
                            n_full  = r_ovf;
                            n_state = S_OUT;
                        end
                        til_pkg::CMD_SEARCH: begin
                            n_state = S_MARK;
                        end
                        default: begin
                            n_found = word_ok;
                            n_full  = 1'b0;
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_MARK: begin
                n_found = word_ok && mark_rdata;
                n_full  = 1'b0;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_rsp_valid || !i_rsp_stall) begin
                    n_rsp.found    = r_found;
                    n_rsp.full_res = r_full;
                    n_rsp_valid    = 1'b1;
                    n_cursor       = '0;
                    n_missed       = 1'b0;
                    n_ovf          = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_used      <= til_pkg::USED_W'(1);
            r_cursor    <= '0;
            r_missed    <= 1'b0;
            r_ovf       <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_used      <= n_used;
            r_cursor    <= n_cursor;
            r_missed    <= n_missed;
            r_ovf       <= n_ovf;
            r_rsp_valid <= n_rsp_valid;
            r_req       <= n_req;
            r_slot      <= n_slot;
            r_found     <= n_found;
            r_full      <= n_full;
            r_rsp       <= n_rsp;
        end
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

// ===== rtl/til_checker.sv =====
// ----------------------------------------------------------------------------
// til_checker
// port-level checks for the prefix trie, bound to the top level
// ----------------------------------------------------------------------------
`include "trie_insert_and_lookup_top_assert.svh"

module til_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          o_req_stall,
    input til_pkg::t_req i_req,
    input logic          o_rsp_valid,
    input logic          i_rsp_stall,
    input til_pkg::t_rsp o_rsp
);

    // a stalled response stays up
    `TIL_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_rsp_valid && i_rsp_stall, o_rsp_valid)

    // a stalled response keeps its payload
    `TIL_ASSERT_NEXT(a_rsp_stable, i_clk, i_rst_n, o_rsp_valid && i_rsp_stall, $stable(o_rsp))

    // found and pool full never come together
    `TIL_ASSERT_NOW(a_rsp_excl, i_clk, i_rst_n, o_rsp_valid, !(o_rsp.found && o_rsp.full_res))

    // one letter at a time: the block stalls right after taking a request
    `TIL_ASSERT_NEXT(a_req_busy, i_clk, i_rst_n, i_req_valid && !o_req_stall, o_req_stall)

endmodule

bind trie_insert_and_lookup_top til_checker u_til_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_stall (o_req_stall),
    .i_req       (i_req),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_stall (i_rsp_stall),
    .o_rsp       (o_rsp)
);

// ===== dv/tb_trie_insert_and_lookup_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trie_insert_and_lookup_top
// letter-serial bench for the prefix trie with an in-bench trie model and an
// in-order response scoreboard, random idling and one long response hold
// ----------------------------------------------------------------------------
module tb_trie_insert_and_lookup_top;

    localparam logic [til_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int HOLD_CYCLES = 400;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_stall = 1'b0;
    til_pkg::t_req req_item = '0;
    logic o_req_stall;
    logic o_rsp_valid;
    til_pkg::t_rsp o_rsp;

    trie_insert_and_lookup_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (req_item),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (o_rsp)
    );

    // trie model
    logic [til_pkg::NODE_W-1:0] link_mem [til_pkg::LINK_DEPTH];
    bit                         mark_mem [til_pkg::NODE_COUNT];
    int unsigned                nodes_used;
    logic [til_pkg::NODE_W-1:0] walk_node;
    bit                         walk_missed;
    bit                         walk_full;

    til_pkg::t_req letters_to_send [$];
    til_pkg::t_rsp word_results_due [$];
    int            mismatches = 0;

    // inserted words, kept to build hits
    logic [til_pkg::LETTER_W-1:0] stored_letters [$];
    int                           stored_start [$];
    int                           stored_len [$];

    function automatic bit trie_apply_letter(input til_pkg::t_req r,
                                             output til_pkg::t_rsp rsp);
        int unsigned                slot;
        logic [til_pkg::NODE_W-1:0] next;
        bit                         ok;
        rsp = '0;
        if (!walk_missed && !walk_full) begin
            if (r.letter >= til_pkg::ALPHABET_SIZE) begin
                walk_missed = 1'b1;
            end else begin
                slot = walk_node * til_pkg::ALPHABET_SIZE + r.letter;
                next = link_mem[slot];
                if (next == '0) begin
                    if (r.cmd != til_pkg::CMD_INSERT) begin
                        walk_missed = 1'b1;
                    end else if (nodes_used >= til_pkg::NODE_COUNT) begin
                        walk_full = 1'b1;
                    end else begin
                        next = nodes_used[til_pkg::NODE_W-1:0];
                        nodes_used++;
                        link_mem[slot] = next;
                    end
                end
                if (!walk_missed && !walk_full) walk_node = next;
            end
        end
        if (!r.last) return 1'b0;
        ok = !walk_missed && !walk_full;
        case (r.cmd)
            til_pkg::CMD_INSERT: begin
                if (ok) mark_mem[walk_node] = 1'b1;
                rsp.full_res = walk_full;
            end
            til_pkg::CMD_SEARCH: rsp.found = ok && mark_mem[walk_node];
            default:             rsp.found = ok;
        endcase
        walk_node   = '0;
        walk_missed = 1'b0;
        walk_full   = 1'b0;
        return 1'b1;
    endfunction

    task automatic queue_req(input logic [til_pkg::CMD_W-1:0] c, input int letter,
                             input bit last);
        til_pkg::t_req r;
        r.cmd    = c;
        r.letter = letter[til_pkg::LETTER_W-1:0];
        r.last   = last;
        letters_to_send = {letters_to_send, r};
    endtask

    task automatic queue_word(input logic [til_pkg::CMD_W-1:0] c, input string w);
        for (int i = 0; i < w.len(); i++) queue_req(c, w[i] - 8'h61, i == w.len() - 1);
    endtask

    task automatic queue_random_word(input int insert_pct, input int min_len,
                                     input int max_len);
        int                          pick;
        int                          k;
        int                          base;
        int                          n;
        int                          m;
        int                          l;
        logic [til_pkg::CMD_W-1:0]   c;
        logic [til_pkg::LETTER_W-1:0] rl;
        pick = $urandom_range(0, 99);
        if (stored_len.size() == 0 || pick < insert_pct) begin
            n = $urandom_range(min_len, max_len);
            stored_start = {stored_start, stored_letters.size()};
            stored_len   = {stored_len, n};
            for (int i = 0; i < n; i++) begin
                rl = til_pkg::LETTER_W'($urandom_range(0, til_pkg::ALPHABET_SIZE - 1));
                stored_letters = {stored_letters, rl};
                queue_req(til_pkg::CMD_INSERT, rl, i == n - 1);
            end
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick >= 88) begin
            // noise: any command per letter, any letter code
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                queue_req(til_pkg::CMD_W'($urandom_range(0, 3)), $urandom_range(0, 31),
                          i == n - 1);
            return;
        end
        k    = $urandom_range(0, stored_len.size() - 1);
        base = stored_start[k];
        n    = stored_len[k];
        m    = -1;
        if (pick < 40) begin
            c = til_pkg::CMD_SEARCH;
        end else if (pick < 60) begin
            c = $urandom_range(0, 1) ? til_pkg::CMD_PREFIX : CMD_SPARE;
            n = $urandom_range(1, n);
        end else if (pick < 70) begin
            c = til_pkg::CMD_SEARCH;
            n = $urandom_range(1, n);
        end else if (pick < 78) begin
            c = til_pkg::CMD_INSERT;
        end else begin
            c = $urandom_range(0, 1) ? til_pkg::CMD_SEARCH : til_pkg::CMD_PREFIX;
            m = $urandom_range(0, n - 1);
        end
        for (int i = 0; i < n; i++) begin
            l = stored_letters[base + i];
            if (i == m) l = $urandom_range(0, til_pkg::ALPHABET_SIZE - 1);
            queue_req(c, l, i == n - 1);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // driver
    int            reqs_sent = 0;
    til_pkg::t_rsp due_rsp;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else if (!req_valid || !o_req_stall) begin
            if (req_valid) begin
                reqs_sent++;
                if (trie_apply_letter(req_item, due_rsp))
                    word_results_due = {word_results_due, due_rsp};
            end
            if (letters_to_send.size() != 0 &&
                ((reqs_sent >= 700 && reqs_sent < 1000) || $urandom_range(0, 99) >= 7)) begin
                req_valid <= 1'b1;
                req_item  <= letters_to_send.pop_front();
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // monitor and response stall
    int            rsps_seen = 0;
    int            hold_left = 0;
    bit            hold_done = 1'b0;
    til_pkg::t_rsp want;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_rsp_valid && !rsp_stall) begin
                rsps_seen++;
                if (word_results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected response, expected none, actual found %0b full %0b",
                             $time, o_rsp.found, o_rsp.full_res);
                end else begin
                    want = word_results_due.pop_front();
                    if (o_rsp.found !== want.found) begin
                        mismatches++;
                        $display("%0t: found expected %0b actual %0b",
                                 $time, want.found, o_rsp.found);
                    end
                    if (o_rsp.full_res !== want.full_res) begin
                        mismatches++;
                        $display("%0t: full_res expected %0b actual %0b",
                                 $time, want.full_res, o_rsp.full_res);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                rsp_stall <= 1'b1;
            end else if (!hold_done && rsps_seen >= 60) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                rsp_stall <= 1'b1;
            end else begin
                rsp_stall <= !(rsps_seen >= 120 && rsps_seen < 180) &&
                             ($urandom_range(0, 99) < 7);
            end
        end
    end

    initial begin
        for (int i = 0; i < til_pkg::LINK_DEPTH; i++) link_mem[i] = '0;
        for (int i = 0; i < til_pkg::NODE_COUNT; i++) mark_mem[i] = 1'b0;
        nodes_used  = 1;
        walk_node   = '0;
        walk_missed = 1'b0;
        walk_full   = 1'b0;

        // directed words
        queue_word(til_pkg::CMD_SEARCH, "a");
        queue_word(til_pkg::CMD_INSERT, "ab");
        queue_word(til_pkg::CMD_SEARCH, "ab");
        queue_word(til_pkg::CMD_SEARCH, "a");
        queue_word(CMD_SPARE, "a");
        queue_word(til_pkg::CMD_INSERT, "z");
        queue_word(til_pkg::CMD_SEARCH, "z");
        queue_req(til_pkg::CMD_INSERT, 2, 1'b0);
        queue_req(til_pkg::CMD_INSERT, 31, 1'b0);
        queue_req(til_pkg::CMD_INSERT, 3, 1'b1);
        queue_word(til_pkg::CMD_PREFIX, "c");
        queue_word(til_pkg::CMD_SEARCH, "c");
        queue_req(til_pkg::CMD_SEARCH, til_pkg::ALPHABET_SIZE, 1'b1);
        queue_req(til_pkg::CMD_INSERT, 16, 1'b0);
        queue_req(til_pkg::CMD_SEARCH, 17, 1'b1);
        queue_word(til_pkg::CMD_PREFIX, "q");
        queue_word(til_pkg::CMD_PREFIX, "ab");
        queue_word(til_pkg::CMD_SEARCH, "xa");

        while (letters_to_send.size() < 800) queue_random_word(55, 3, 12);
        // long inserts to run the node pool dry
        while (letters_to_send.size() < 1450) queue_random_word(100, 16, 24);
        while (letters_to_send.size() < 1750) queue_random_word(40, 2, 10);

        while (letters_to_send.size() != 0 || req_valid) @(posedge i_clk);
        while (word_results_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && word_results_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/til_pkg.sv
rtl/til_ram.sv
rtl/trie_insert_and_lookup_top.sv
rtl/til_checker.sv
dv/tb_trie_insert_and_lookup_top.sv
